// File: rtl/dtu_pkg.sv
// Shared types, constants and decode functions for the date text converter.
`default_nettype none

package dtu_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BACK_STAGES = 5;
    localparam int CAPACITY = 1 + QUEUE_DEPTH + BACK_STAGES;
    localparam int INFLIGHT_W = $clog2(CAPACITY + 1);

    typedef logic [7:0] char_t;
    typedef logic signed [8:0] digit_t;
    typedef logic signed [12:0] pair_t;
    typedef logic signed [18:0] year_t;
    typedef logic [3:0] month_t;
    typedef logic signed [12:0] doy_t;
    typedef logic signed [24:0] tod_t;

    typedef struct packed {
        year_t yc;
        doy_t  doy;
        tod_t  tod;
    } front_word_t;

    localparam char_t CHAR_SPACE = 8'h20;
    localparam digit_t DIGIT_ZERO = 9'sd48;
    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;
    localparam int MONTH_NAME_COUNT = 11;

    localparam logic [23:0] MONTH_NAMES [MONTH_NAME_COUNT] = '{
        24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
        24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76
    };

    localparam logic signed [19:0] YEAR_BIAS = 20'sd53600;
    localparam logic signed [11:0] ERA_BIAS = 12'sd134;
    localparam logic [15:0] DIV25_MULT = 16'd41944;
    localparam logic [18:0] ERA_YEARS = 19'd400;
    localparam logic signed [18:0] DAYS_PER_YEAR = 19'sd365;
    localparam logic signed [31:0] DAYS_PER_ERA = 32'sd146097;
    localparam logic signed [31:0] EPOCH_OFFSET = 32'sd719468;
    localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

    function automatic digit_t char_val(input char_t c);
        digit_t v;
        if (c == CHAR_SPACE)
        begin
            v = '0;
        end
        else
        begin
            v = $signed({1'b0, c}) - DIGIT_ZERO;
        end
        return v;
    endfunction

    function automatic pair_t two_chars(input logic [15:0] v);
        pair_t tens;
        pair_t ones;
        tens = pair_t'(char_val(v[15:8]));
        ones = pair_t'(char_val(v[7:0]));
        return tens * 13'sd10 + ones;
    endfunction

    function automatic month_t month_num(input logic [23:0] t);
        month_t m;
        m = MONTH_DEC;
        for (int i = 0; i < MONTH_NAME_COUNT; i++)
        begin
            if (MONTH_NAMES[i] == t)
            begin
                m = month_t'(i + 1);
            end
        end
        return m;
    endfunction

    // Days from the start of a March-based year to the first of the month.
    function automatic doy_t month_base(input month_t m);
        doy_t b;
        case (m)
            4'd1:    b = 13'sd306;
            4'd2:    b = 13'sd337;
            4'd3:    b = 13'sd0;
            4'd4:    b = 13'sd31;
            4'd5:    b = 13'sd61;
            4'd6:    b = 13'sd92;
            4'd7:    b = 13'sd122;
            4'd8:    b = 13'sd153;
            4'd9:    b = 13'sd184;
            4'd10:   b = 13'sd214;
            4'd11:   b = 13'sd245;
            4'd12:   b = 13'sd275;
            default: b = 13'sd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dtu_if.sv
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface dtu_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] month_text;
    logic [15:0] day_text;
    logic [31:0] year_text;
    logic [15:0] hour_text;
    logic [15:0] minute_text;
    logic [15:0] second_text;

    modport source (
        output valid, month_text, day_text, year_text, hour_text, minute_text,
               second_text,
        input  ready
    );
    modport sink (
        input  valid, month_text, day_text, year_text, hour_text, minute_text,
               second_text,
        output ready
    );
endinterface

interface dtu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] day_count;
    logic [48:0] unix_seconds;

    modport source (
        output valid, day_count, unix_seconds,
        input  ready
    );
    modport sink (
        input  valid, day_count, unix_seconds,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/date_text_to_unix_seconds_unit.sv
// Top level: converts date and time text words into Unix day and second counts.
//
//   Channel  Dir  Word contents
//   req      in   month_text, day_text, year_text, hour_text, minute_text, second_text
//   rsp      out  day_count, unix_seconds
//
// One word is accepted per cycle unless a stall on rsp has filled the pipeline.
// A word passes through the decode register, the queue, then five back stages.
// Reset clears the valid flags, the queue pointers and the queue count; no other state is kept between words.
// A stall on rsp fills the back stages, the queue and the decode register, then drops req.ready.
`default_nettype none

module date_text_to_unix_seconds_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dtu_in_if.sink     req,
    dtu_out_if.source  rsp
);
    import dtu_pkg::*;

    logic        fr_valid;
    logic        fr_ready;
    front_word_t fr_word;
    logic        q_valid;
    logic        q_ready;
    front_word_t q_word;

    dtu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .word_valid (fr_valid),
        .word_ready (fr_ready),
        .word       (fr_word)
    );

    dtu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_word   (fr_word),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_word  (q_word)
    );

    dtu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_word  (q_word),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/dtu_front.sv
// Front stage: decodes the date and time text into a compact registered word.
`default_nettype none

module dtu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    dtu_in_if.sink                 req,
    output logic                   word_valid,
    input  wire logic              word_ready,
    output dtu_pkg::front_word_t   word
);
    import dtu_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    front_word_t word_reg;
    front_word_t dec;
    year_t       year;
    month_t      month;
    pair_t       day;
    year_t       hm;

    always_comb
    begin
        year  = year_t'(char_val(req.year_text[31:24])) * 19'sd1000
              + year_t'(char_val(req.year_text[23:16])) * 19'sd100
              + year_t'(char_val(req.year_text[15:8])) * 19'sd10
              + year_t'(char_val(req.year_text[7:0]));
        month = month_num(req.month_text);
        day   = two_chars(req.day_text);
        hm    = year_t'(two_chars(req.hour_text)) * 19'sd60
              + year_t'(two_chars(req.minute_text));
        dec.yc  = (month <= MONTH_FEB) ? year - 19'sd1 : year;
        dec.doy = month_base(month) + day - 13'sd1;
        dec.tod = tod_t'(hm) * 25'sd60 + tod_t'(two_chars(req.second_text));
    end

    assign req.ready = !valid_reg || word_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.valid && req.ready)
        begin
            valid_next = 1'b1;
        end
        else if (word_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            word_reg <= dec;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

// File: rtl/dtu_queue.sv
// Short queue that decouples the decode front from the arithmetic back.
`default_nettype none

module dtu_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dtu_pkg::front_word_t  in_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output dtu_pkg::front_word_t       out_word
);
    import dtu_pkg::*;

    front_word_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic                     push;
    logic                     pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

`default_nettype wire

// File: rtl/dtu_back.sv
// Back pipeline: era split, day count and seconds, ending in the output register.
`default_nettype none

module dtu_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dtu_pkg::front_word_t  in_word,
    dtu_out_if.source                  rsp
);
    import dtu_pkg::*;

    logic [BACK_STAGES-1:0] valid_reg;
    logic [BACK_STAGES-1:0] valid_next;
    logic [BACK_STAGES-1:0] advance;

    // Stage 1: biased year and its quotient by 400.
    logic [18:0]        yp_1_reg;
    logic [10:0]        q_1_reg;
    doy_t               doy_1_reg;
    tod_t               tod_1_reg;
    // Stage 2: era and year of era.
    logic signed [10:0] era_2_reg;
    logic [8:0]         yoe_2_reg;
    doy_t               doy_2_reg;
    tod_t               tod_2_reg;
    // Stage 3: era days and day of era.
    logic signed [31:0] era_days_3_reg;
    logic signed [18:0] doe_3_reg;
    tod_t               tod_3_reg;
    // Stage 4: day count.
    logic [31:0]        days_4_reg;
    tod_t               tod_4_reg;
    // Stage 5: output register.
    logic [31:0]        day_count_reg;
    logic [48:0]        unix_seconds_reg;

    logic signed [19:0] yp_sum;
    logic [18:0]        yp;
    logic [30:0]        prod;
    logic [18:0]        yoe_w;
    logic signed [11:0] era_w;
    logic [1:0]         cent;
    logic signed [18:0] doe_w;
    logic signed [31:0] era_days_w;
    logic signed [31:0] days_w;
    logic [31:0]        tod_u;
    logic [48:0]        secs_w;

    always_comb
    begin
        advance[BACK_STAGES-1] = !valid_reg[BACK_STAGES-1] || rsp.ready;
        for (int k = BACK_STAGES - 2; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
        valid_next[0] = advance[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < BACK_STAGES; k++)
        begin
            valid_next[k] = advance[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign in_ready = advance[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        // Floor division by 400: bias to positive, drop the low four bits (divide by 16), divide by 25.
        yp_sum = 20'(in_word.yc) + YEAR_BIAS;
        yp     = yp_sum[18:0];
        prod   = 31'(yp[18:4]) * 31'(DIV25_MULT);

        yoe_w = yp_1_reg - 19'(19'(q_1_reg) * ERA_YEARS);
        era_w = $signed({1'b0, q_1_reg}) - ERA_BIAS;

        cent = 2'(yoe_2_reg >= 9'd100) + 2'(yoe_2_reg >= 9'd200)
             + 2'(yoe_2_reg >= 9'd300);
        doe_w = $signed({10'b0, yoe_2_reg}) * DAYS_PER_YEAR
              + $signed({12'b0, yoe_2_reg[8:2]})
              - $signed({17'b0, cent})
              + 19'(doy_2_reg);
        era_days_w = 32'(era_2_reg) * DAYS_PER_ERA;

        days_w = era_days_3_reg + 32'(doe_3_reg) - EPOCH_OFFSET;

        tod_u  = 32'(tod_4_reg);
        secs_w = 49'(days_4_reg) * 49'(SECONDS_PER_DAY) + 49'(tod_u);
    end

    always_ff @(posedge clk)
    begin
        if (advance[0])
        begin
            yp_1_reg  <= yp;
            q_1_reg   <= prod[30:20];
            doy_1_reg <= in_word.doy;
            tod_1_reg <= in_word.tod;
        end
        if (advance[1])
        begin
            era_2_reg <= era_w[10:0];
            yoe_2_reg <= yoe_w[8:0];
            doy_2_reg <= doy_1_reg;
            tod_2_reg <= tod_1_reg;
        end
        if (advance[2])
        begin
            era_days_3_reg <= era_days_w;
            doe_3_reg      <= doe_w;
            tod_3_reg      <= tod_2_reg;
        end
        if (advance[3])
        begin
            days_4_reg <= days_w;
            tod_4_reg  <= tod_3_reg;
        end
        if (advance[4])
        begin
            day_count_reg    <= days_4_reg;
            unix_seconds_reg <= secs_w;
        end
    end

    assign rsp.valid        = valid_reg[BACK_STAGES-1];
    assign rsp.day_count    = day_count_reg;
    assign rsp.unix_seconds = unix_seconds_reg;

endmodule

`default_nettype wire

// File: rtl/dtu_checker.sv
// Port-level checks for the converter, attached to the top level by bind.
`default_nettype none

module dtu_port_checks (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [31:0] rsp_day_count,
    input wire logic [48:0] rsp_unix_seconds
);
    import dtu_pkg::*;

    logic [INFLIGHT_W-1:0] inflight_reg;
    logic [INFLIGHT_W-1:0] inflight_next;
    logic [48:0]           tod_part;

    always_comb
    begin
        inflight_next = inflight_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    assign tod_part = rsp_unix_seconds - 49'(rsp_day_count) * 49'(SECONDS_PER_DAY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("Response word dropped while stalled.");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> inflight_reg != '0)
        else $error("Response word without a pending request.");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == INFLIGHT_W'(CAPACITY) |-> !req_ready)
        else $error("Request accepted with every slot occupied.");

    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> tod_part[48:32] == '0)
        else $error("Seconds do not match the day count.");

endmodule

bind date_text_to_unix_seconds_unit dtu_port_checks u_dtu_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_day_count    (rsp.day_count),
    .rsp_unix_seconds (rsp.unix_seconds)
);

`default_nettype wire

// File: bench/dtu_checker.sv
// Checker that predicts each conversion and compares it with the response channel.
`default_nettype none

module dtu_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    dtu_in_if         req,
    dtu_out_if        rsp,
    output int        fail_count,
    output int        stamps_waiting
);
    import dtu_pkg::*;

    localparam logic [31:0] ASCII_ZERO = 32'h30;
    localparam logic [31:0] ASCII_SPACE = 32'h20;
    localparam int ERA_YEARS_SIGNED = 400;
    localparam logic [31:0] YEARS_IN_ERA = 32'd400;
    localparam logic [31:0] YEAR_DAYS = 32'd365;
    localparam logic [31:0] ERA_DAYS = 32'd146097;
    localparam logic [31:0] CIVIL_EPOCH_DAYS = 32'd719468;
    localparam logic [63:0] DAY_SECONDS = 64'd86400;

    typedef struct packed {
        logic [31:0] day_count;
        logic [48:0] unix_seconds;
    } stamp_t;

    stamp_t stamps[$];
    int     mismatches = 0;
    int     held = 0;

    assign fail_count = mismatches;
    assign stamps_waiting = held;

    function automatic logic [31:0] digit_of(input logic [7:0] c);
        logic [31:0] v;
        v = {24'd0, c};
        if (v == ASCII_SPACE)
        begin
            v = ASCII_ZERO;
        end
        return v - ASCII_ZERO;
    endfunction

    function automatic logic [31:0] pair_of(input logic [15:0] t);
        return digit_of(t[15:8]) * 32'd10 + digit_of(t[7:0]);
    endfunction

    function automatic logic [31:0] month_of(input logic [23:0] t);
        logic [31:0] m;
        m = 32'(MONTH_DEC);
        for (int i = 0; i < MONTH_NAME_COUNT; i++)
        begin
            if (MONTH_NAMES[i] == t)
            begin
                m = 32'(i + 1);
            end
        end
        return m;
    endfunction

    function automatic logic [31:0] civil_day_count(input logic [31:0] y,
                                                    input logic [31:0] m,
                                                    input logic [31:0] d);
        logic [31:0] yc;
        logic [31:0] shifted;
        int          era;
        logic [31:0] era_u;
        logic [31:0] yoe;
        logic [31:0] mp;
        logic [31:0] doy;
        logic [31:0] doe;
        yc = (m <= 32'(MONTH_FEB)) ? y - 32'd1 : y;
        shifted = yc[31] ? yc - (YEARS_IN_ERA - 32'd1) : yc;
        era = $signed(shifted) / ERA_YEARS_SIGNED;
        era_u = era;
        yoe = yc - era_u * YEARS_IN_ERA;
        mp = (m > 32'(MONTH_FEB)) ? m - 32'd3 : m + 32'd9;
        doy = (32'd153 * mp + 32'd2) / 32'd5 + d - 32'd1;
        doe = yoe * YEAR_DAYS + yoe / 32'd4 - yoe / 32'd100 + doy;
        return era_u * ERA_DAYS + doe - CIVIL_EPOCH_DAYS;
    endfunction

    function automatic stamp_t predict_stamp(input logic [23:0] month_text,
                                             input logic [15:0] day_text,
                                             input logic [31:0] year_text,
                                             input logic [15:0] hour_text,
                                             input logic [15:0] minute_text,
                                             input logic [15:0] second_text);
        logic [31:0] year;
        logic [31:0] tod;
        logic [63:0] secs;
        stamp_t      s;
        year = digit_of(year_text[31:24]) * 32'd1000 + digit_of(year_text[23:16]) * 32'd100
             + digit_of(year_text[15:8]) * 32'd10 + digit_of(year_text[7:0]);
        s.day_count = civil_day_count(year, month_of(month_text), pair_of(day_text));
        tod = (pair_of(hour_text) * 32'd60 + pair_of(minute_text)) * 32'd60
            + pair_of(second_text);
        secs = {32'd0, s.day_count} * DAY_SECONDS + {32'd0, tod};
        s.unix_seconds = secs[48:0];
        return s;
    endfunction

    always @(posedge clk)
    begin
        stamp_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (stamps.size() == 0)
                begin
                    $display("%0t: unexpected word, day_count %h unix_seconds %h",
                             $time, rsp.day_count, rsp.unix_seconds);
                    mismatches++;
                end
                else
                begin
                    want = stamps.pop_front();
                    if (rsp.day_count !== want.day_count)
                    begin
                        $display("%0t: day_count expected %h actual %h",
                                 $time, want.day_count, rsp.day_count);
                        mismatches++;
                    end
                    if (rsp.unix_seconds !== want.unix_seconds)
                    begin
                        $display("%0t: unix_seconds expected %h actual %h",
                                 $time, want.unix_seconds, rsp.unix_seconds);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                stamps.push_back(predict_stamp(req.month_text, req.day_text, req.year_text,
                                               req.hour_text, req.minute_text,
                                               req.second_text));
            end
            held = stamps.size();
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_date_text_to_unix_seconds_unit.sv
// Testbench top: drives date words into the converter and reports the verdict.
`default_nettype none

module tb_date_text_to_unix_seconds_unit;
    import dtu_pkg::*;

    localparam int DATE_COUNT = 650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_OFF_AFTER = 200;
    localparam int HOLD_OFF_CYCLES = 90;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [23:0] DEC_NAME = 24'h446563;
    localparam logic [23:0] DEC_LOWER = 24'h646563;
    localparam logic [23:0] JAN_UPPER = 24'h4A414E;

    typedef struct packed {
        logic [23:0] month_text;
        logic [15:0] day_text;
        logic [31:0] year_text;
        logic [15:0] hour_text;
        logic [15:0] minute_text;
        logic [15:0] second_text;
    } date_word_t;

    logic clk;
    logic rst_n;
    int   dates_sent = 0;
    int   burst_left = 0;
    int   fail_count;
    int   stamps_waiting;

    dtu_in_if  req_ch ();
    dtu_out_if rsp_ch ();

    date_text_to_unix_seconds_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dtu_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .fail_count     (fail_count),
        .stamps_waiting (stamps_waiting)
    );

    function automatic logic [15:0] text2(input int v);
        return {ASCII_ZERO + 8'(v / 10), ASCII_ZERO + 8'(v % 10)};
    endfunction

    function automatic logic [31:0] text4(input int v);
        return {text2(v / 100), text2(v % 100)};
    endfunction

    function automatic date_word_t make_date(input logic [23:0] mon, input logic [15:0] day,
                                             input logic [31:0] year, input logic [15:0] hour,
                                             input logic [15:0] minute,
                                             input logic [15:0] second);
        return '{mon, day, year, hour, minute, second};
    endfunction

    function automatic logic [7:0] rand_char();
        int k;
        k = $urandom_range(0, 19);
        if (k < 15)
        begin
            return ASCII_ZERO + 8'($urandom_range(0, 9));
        end
        else if (k < 17)
        begin
            return CHAR_SPACE;
        end
        return 8'($urandom);
    endfunction

    function automatic date_word_t random_date();
        date_word_t w;
        int         mode;
        int         pick;
        int         day;
        mode = $urandom_range(0, 99);
        pick = $urandom_range(0, 12);
        if (pick < MONTH_NAME_COUNT)
        begin
            w.month_text = MONTH_NAMES[pick];
        end
        else if (pick == MONTH_NAME_COUNT)
        begin
            w.month_text = DEC_NAME;
        end
        else
        begin
            w.month_text = 24'($urandom);
        end
        if (mode < 70)
        begin
            day = $urandom_range(1, 31);
            w.day_text = text2(day);
            if (day < 10 && $urandom_range(0, 3) == 0)
            begin
                w.day_text[15:8] = CHAR_SPACE;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                w.year_text = text4($urandom_range(0, 9999));
            end
            else
            begin
                w.year_text = text4($urandom_range(1600, 2400));
            end
            w.hour_text = text2($urandom_range(0, 23));
            w.minute_text = text2($urandom_range(0, 59));
            w.second_text = text2($urandom_range(0, 59));
        end
        else if (mode < 90)
        begin
            w.day_text = {rand_char(), rand_char()};
            w.year_text = {rand_char(), rand_char(), rand_char(), rand_char()};
            w.hour_text = {rand_char(), rand_char()};
            w.minute_text = {rand_char(), rand_char()};
            w.second_text = {rand_char(), rand_char()};
        end
        else
        begin
            w.month_text = 24'($urandom);
            w.day_text = 16'($urandom);
            w.year_text = $urandom;
            w.hour_text = 16'($urandom);
            w.minute_text = 16'($urandom);
            w.second_text = 16'($urandom);
        end
        return w;
    endfunction

    // Called at a falling edge; opens a new burst after a random gap when the last one ends.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic offer_date(input date_word_t w);
        req_ch.valid       <= 1'b1;
        req_ch.month_text  <= w.month_text;
        req_ch.day_text    <= w.day_text;
        req_ch.year_text   <= w.year_text;
        req_ch.hour_text   <= w.hour_text;
        req_ch.minute_text <= w.minute_text;
        req_ch.second_text <= w.second_text;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        dates_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int tick;
        int seg_len;
        int seg_kind;
        bit held_off;
        held_off = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            // One long hold-off lets the back stages and the queue fill up.
            if (!held_off && dates_sent >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            seg_len = $urandom_range(16, 120);
            seg_kind = $urandom_range(0, 3);
            for (tick = 0; tick < seg_len; tick++)
            begin
                @(negedge clk);
                case (seg_kind)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    initial
    begin
        date_word_t directed[$];
        req_ch.valid = 1'b0;
        req_ch.month_text = '0;
        req_ch.day_text = '0;
        req_ch.year_text = '0;
        req_ch.hour_text = '0;
        req_ch.minute_text = '0;
        req_ch.second_text = '0;
        wait (rst_n);
        @(negedge clk);

        directed.push_back(make_date(MONTH_NAMES[0], text2(1), text4(1970), text2(0), text2(0),
                                     text2(0)));
        for (int i = 1; i < MONTH_NAME_COUNT; i++)
        begin
            directed.push_back(make_date(MONTH_NAMES[i], text2(i * 2 + 5), text4(1990 + i * 3),
                                         text2(i + 5), text2(i * 5), text2(59 - i)));
        end
        directed.push_back(make_date(DEC_NAME, text2(31), text4(1969), text2(23), text2(59),
                                     text2(59)));
        directed.push_back(make_date(MONTH_NAMES[1], text2(29), text4(2000), text2(23),
                                     text2(59), text2(59)));
        directed.push_back(make_date(MONTH_NAMES[2], {CHAR_SPACE, ASCII_ZERO + 8'd1},
                                     text4(2100), 16'h2020, 16'h2020, 16'h2020));
        directed.push_back(make_date(MONTH_NAMES[0], text2(1), text4(0), text2(0), text2(0),
                                     text2(0)));
        directed.push_back(make_date(DEC_LOWER, text2(31), text4(9999), text2(99), text2(99),
                                     text2(99)));
        directed.push_back(make_date('0, '0, '0, '0, '0, '0));
        directed.push_back(make_date('1, '1, '1, '1, '1, '1));
        directed.push_back(make_date(JAN_UPPER, text2(99), 32'h20202020, text2(12), text2(0),
                                     text2(0)));
        directed.push_back(make_date(MONTH_NAMES[1], 16'h2F7E, 32'h3A3B3C3D, 16'h2F2F,
                                     16'h0A7F, 16'h8020));
        directed.push_back(make_date(MONTH_NAMES[1], text2(28), 32'h20202020, text2(0),
                                     text2(0), text2(1)));

        foreach (directed[i])
        begin
            pace_sender();
            offer_date(directed[i]);
        end
        repeat (DATE_COUNT)
        begin
            pace_sender();
            offer_date(random_date());
        end
        req_ch.valid <= 1'b0;

        while (stamps_waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
